@@ hw/rtl/simcc_pkg.sv @@
`default_nettype none

package simcc_pkg;

	localparam int SCORE_W   = 16;
	localparam int FACTOR_W  = 16;
	localparam int COORD_W   = 27;
	localparam int CFG_IDX_W = 1;

	typedef logic signed [SCORE_W-1:0]  score_t;
	typedef logic        [FACTOR_W-1:0] factor_t;
	typedef logic signed [COORD_W-1:0]  coord_t;
	typedef logic        [CFG_IDX_W-1:0] cfg_idx_t;

	// register map
	localparam cfg_idx_t REG_X_FACTOR = 1'd0;
	localparam cfg_idx_t REG_Y_FACTOR = 1'd1;

	localparam factor_t FACTOR_RESET = 16'd128;   // 0.5 in Q8.8

	// largest coordinate the field holds, and -1.0 in Q.8
	localparam logic [32:0] COORD_MAX     = 33'd67108863;
	localparam coord_t      COORD_INVALID = -27'sd256;

endpackage

`default_nettype wire

@@ hw/rtl/simcc_keypoint_decoder.sv @@
// Channel  | handshake           | payload
// ---------+---------------------+-------------------------------------------
// bin      | bin_valid/bin_stall | score_value, axis, row_last
// res      | res_valid/res_stall | coord_x, coord_y, score, found
// cfg      | cfg_valid/cfg_ready | cfg_index, cfg_data (0 x_factor, 1 y_factor)
//
// One bin item is taken every cycle while bin_stall is low. A bin passes an
// input register (s1), where the running maximum and bin counter update; a y
// row's last bin also loads a snapshot stage (s2), whose two 16 x IDX_W
// multipliers and the min compare feed the result register.
// arst_n clears the maxima, indices, counter and valids; factors reset to 0.5.
// res_stall only holds back the bin channel once s1, s2 and the result
// register all hold a pending result. cfg_ready is always high.
`default_nettype none

module simcc_keypoint_decoder #(
	parameter int MAX_BINS = 1024
) (
	input  wire                      clk,
	input  wire                      arst_n,
	// bin channel
	input  wire                      bin_valid,
	output logic                     bin_stall,
	input  simcc_pkg::score_t        score_value,
	input  wire                      axis,
	input  wire                      row_last,
	// result channel
	output logic                     res_valid,
	input  wire                      res_stall,
	output simcc_pkg::coord_t        coord_x,
	output simcc_pkg::coord_t        coord_y,
	output simcc_pkg::score_t        score,
	output logic                     found,
	// configuration channel
	input  wire                      cfg_valid,
	output logic                     cfg_ready,
	input  simcc_pkg::cfg_idx_t      cfg_index,
	input  simcc_pkg::factor_t       cfg_data
);
	import simcc_pkg::*;

	localparam int IDX_W  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int PROD_W = IDX_W + FACTOR_W;
	localparam logic [IDX_W-1:0] CNT_LAST = IDX_W'(MAX_BINS - 1);

	// configuration
	factor_t x_factor_q, y_factor_q;

	// input stage
	logic    valid_s1, axis_s1, last_s1;
	score_t  value_s1;

	// running state
	score_t            best_x_val_q, best_y_val_q;
	logic [IDX_W-1:0]  best_x_idx_q, best_y_idx_q;
	logic [IDX_W-1:0]  cnt_q;

	// snapshot stage
	logic              valid_s2;
	score_t            bx_val_s2, by_val_s2;
	logic [IDX_W-1:0]  bx_idx_s2, by_idx_s2;

	// result register
	logic    res_valid_q, found_q;
	coord_t  coord_x_q, coord_y_q;
	score_t  score_q;

	// flow control
	logic fire_s1, s1_adv, s2_free, out_free;

	// s1 update
	score_t            best_sel;
	logic              take;
	score_t            nx_x_val, nx_y_val;
	logic [IDX_W-1:0]  nx_x_idx, nx_y_idx;

	// s2 arithmetic
	score_t        min_val;
	logic          found_d;
	logic [PROD_W-1:0] prod_x, prod_y;
	logic [32:0]   prod_x_ext, prod_y_ext;
	coord_t        cx_d, cy_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_factor_q <= FACTOR_RESET;
			y_factor_q <= FACTOR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_X_FACTOR: x_factor_q <= cfg_data;
				REG_Y_FACTOR: y_factor_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Only a result-bearing bin can be held in s1.
	assign out_free  = !res_valid_q || !res_stall;
	assign s2_free   = !valid_s2 || out_free;
	assign fire_s1   = axis_s1 && last_s1;
	assign s1_adv    = valid_s1 && (!fire_s1 || s2_free);
	assign bin_stall = valid_s1 && !s1_adv;

	// --- s1: compare and update ---
	assign best_sel = axis_s1 ? best_y_val_q : best_x_val_q;
	// first bin of a row always loads; ties keep the earlier bin
	assign take     = (cnt_q == '0) || (value_s1 > best_sel);

	always_comb begin
		nx_x_val = best_x_val_q;
		nx_x_idx = best_x_idx_q;
		nx_y_val = best_y_val_q;
		nx_y_idx = best_y_idx_q;
		if (take) begin
			if (axis_s1) begin
				nx_y_val = value_s1;
				nx_y_idx = cnt_q;
			end else begin
				nx_x_val = value_s1;
				nx_x_idx = cnt_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			best_x_val_q <= '0;
			best_x_idx_q <= '0;
			best_y_val_q <= '0;
			best_y_idx_q <= '0;
			cnt_q        <= '0;
		end else begin
			if (!bin_stall)
				valid_s1 <= bin_valid;
			if (s1_adv) begin
				best_x_val_q <= nx_x_val;
				best_x_idx_q <= nx_x_idx;
				best_y_val_q <= nx_y_val;
				best_y_idx_q <= nx_y_idx;
				// counter saturates on overlong rows
				if (last_s1)
					cnt_q <= '0;
				else if (cnt_q < CNT_LAST)
					cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (bin_valid && !bin_stall) begin
			value_s1 <= score_value;
			axis_s1  <= axis;
			last_s1  <= row_last;
		end
	end

	// --- s2: snapshot of both winners at the end of a y row ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (s2_free)
			valid_s2 <= s1_adv && fire_s1;
	end

	always_ff @(posedge clk) begin
		if (s2_free && s1_adv && fire_s1) begin
			bx_val_s2 <= nx_x_val;
			bx_idx_s2 <= nx_x_idx;
			by_val_s2 <= nx_y_val;
			by_idx_s2 <= nx_y_idx;
		end
	end

	assign min_val = (bx_val_s2 < by_val_s2) ? bx_val_s2 : by_val_s2;
	assign found_d = (min_val > 0);

	assign prod_x     = PROD_W'(bx_idx_s2) * PROD_W'(x_factor_q);
	assign prod_y     = PROD_W'(by_idx_s2) * PROD_W'(y_factor_q);
	assign prod_x_ext = 33'(prod_x);
	assign prod_y_ext = 33'(prod_y);

	// clip to the field, then force -1.0 when nothing was found
	always_comb begin
		cx_d = (prod_x_ext > COORD_MAX) ? coord_t'(COORD_MAX[COORD_W-1:0])
		                                : coord_t'(prod_x_ext[COORD_W-1:0]);
		cy_d = (prod_y_ext > COORD_MAX) ? coord_t'(COORD_MAX[COORD_W-1:0])
		                                : coord_t'(prod_y_ext[COORD_W-1:0]);
		if (!found_d) begin
			cx_d = COORD_INVALID;
			cy_d = COORD_INVALID;
		end
	end

	// --- result register ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (out_free)
			res_valid_q <= valid_s2;
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s2) begin
			coord_x_q <= cx_d;
			coord_y_q <= cy_d;
			score_q   <= min_val;
			found_q   <= found_d;
		end
	end

	assign res_valid = res_valid_q;
	assign coord_x   = coord_x_q;
	assign coord_y   = coord_y_q;
	assign score     = score_q;
	assign found     = found_q;

endmodule

`default_nettype wire

@@ hw/rtl/simcc_checker.sv @@
`default_nettype none

module simcc_checker (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 bin_valid,
	input wire                 bin_stall,
	input wire                 res_valid,
	input wire                 res_stall,
	input simcc_pkg::coord_t   coord_x,
	input simcc_pkg::coord_t   coord_y,
	input simcc_pkg::score_t   score,
	input wire                 found
);
	import simcc_pkg::*;

	// a held result keeps its payload
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(coord_x) && $stable(coord_y)
			&& $stable(score) && $stable(found))
		else $error("result changed while stalled");

	a_found_score: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (found == (score > 0)))
		else $error("found disagrees with score");

	a_invalid_coord: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !found |-> (coord_x == COORD_INVALID) && (coord_y == COORD_INVALID))
		else $error("lost keypoint without -1.0 coordinates");

	a_valid_coord: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && found |-> (coord_x >= 0) && (coord_y >= 0))
		else $error("found keypoint with negative coordinate");

	// the bin side only backs up behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		bin_valid && bin_stall |-> res_valid && res_stall)
		else $error("bin channel stalled without a held result");

endmodule

bind simcc_keypoint_decoder simcc_checker u_simcc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.bin_valid (bin_valid),
	.bin_stall (bin_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.coord_x   (coord_x),
	.coord_y   (coord_y),
	.score     (score),
	.found     (found)
);

`default_nettype wire

@@ dv/tb.sv @@
`default_nettype none

module tb;
	import simcc_pkg::*;

	// row codes on the axis field
	localparam logic AXIS_X = 1'b0;
	localparam logic AXIS_Y = 1'b1;

	localparam int MAX_BINS       = 1024;
	localparam int IDX_W          = $clog2(MAX_BINS);
	localparam int DRAIN_CYCLES   = 8;
	localparam int HOLD_CYCLES    = 300;     // long receiver hold-off
	localparam int ITEM_TARGET    = 1600;
	localparam int CHUNK_ITEMS    = 130;
	localparam int LONG_ROW_ITEMS = MAX_BINS + 6;
	localparam int CYCLE_LIMIT    = 400000;

	typedef struct packed {
		score_t value;
		logic   axis;
		logic   last;
	} bin_item_t;

	typedef struct packed {
		coord_t cx;
		coord_t cy;
		score_t sc;
		logic   fnd;
	} keypoint_t;

	logic clk;
	logic arst_n = 1'b0;

	logic     bin_valid   = 1'b0;
	logic     bin_stall;
	score_t   score_value = '0;
	logic     axis        = AXIS_X;
	logic     row_last    = 1'b0;

	logic     res_valid;
	logic     res_stall   = 1'b0;
	coord_t   coord_x;
	coord_t   coord_y;
	score_t   score;
	logic     found;

	logic     cfg_valid   = 1'b0;
	logic     cfg_ready;
	cfg_idx_t cfg_index   = REG_X_FACTOR;
	factor_t  cfg_data    = '0;

	simcc_keypoint_decoder #(
		.MAX_BINS(MAX_BINS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.bin_valid  (bin_valid),
		.bin_stall  (bin_stall),
		.score_value(score_value),
		.axis       (axis),
		.row_last   (row_last),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.coord_x    (coord_x),
		.coord_y    (coord_y),
		.score      (score),
		.found      (found),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// bins waiting to go out, keypoints waiting to come back
	bin_item_t pending_bins[$];
	keypoint_t expected_kp[$];

	// shadow of the decoder: factors, running maxima and the shared bin counter
	factor_t           shadow_xf  = FACTOR_RESET;
	factor_t           shadow_yf  = FACTOR_RESET;
	score_t            max_x      = '0;
	score_t            max_y      = '0;
	logic [IDX_W-1:0]  idx_x      = '0;
	logic [IDX_W-1:0]  idx_y      = '0;
	logic [IDX_W-1:0]  bin_count  = '0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int errors        = 0;
	int items_made    = 0;
	int cycle_count   = 0;

	// pressure: one long hold-off on the result side, own counter
	logic hold_req  = 1'b0;
	logic hold_used = 1'b0;
	int   hold_left = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// index times factor, clipped to what the 27-bit field holds
	function automatic coord_t scale_coord(input logic [IDX_W-1:0] idx, input factor_t f);
		logic [32:0] prod;
		prod = 33'(idx) * 33'(f);
		if (prod > COORD_MAX)
			prod = COORD_MAX;
		return coord_t'(prod[COORD_W-1:0]);
	endfunction

	// advance the shadow by one accepted bin; a y row end yields a keypoint
	task automatic track_bin(input bin_item_t b);
		keypoint_t kp;
		score_t    lo;
		// first bin of a row always loads; ties keep the earlier bin
		if (b.axis == AXIS_Y) begin
			if (bin_count == '0 || b.value > max_y) begin
				max_y = b.value;
				idx_y = bin_count;
			end
		end else begin
			if (bin_count == '0 || b.value > max_x) begin
				max_x = b.value;
				idx_x = bin_count;
			end
		end
		// counter shared by both rows, sticks at the top
		if (b.last)
			bin_count = '0;
		else if (bin_count < IDX_W'(MAX_BINS - 1))
			bin_count = bin_count + 1'b1;
		if (b.axis == AXIS_Y && b.last) begin
			lo     = (max_x < max_y) ? max_x : max_y;
			kp.sc  = lo;
			kp.fnd = (lo > 0);
			kp.cx  = kp.fnd ? scale_coord(idx_x, shadow_xf) : COORD_INVALID;
			kp.cy  = kp.fnd ? scale_coord(idx_y, shadow_yf) : COORD_INVALID;
			expected_kp.insert(expected_kp.size(), kp);
		end
	endtask

	task automatic check_keypoint(input keypoint_t got);
		keypoint_t want;
		if (expected_kp.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected keypoint x=%0d y=%0d score=%0d found=%0b",
					got.cx, got.cy, got.sc, got.fnd);
		end else begin
			want = expected_kp.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display({"keypoint mismatch: exp x=%0d y=%0d score=%0d found=%0b,",
						" got x=%0d y=%0d score=%0d found=%0b"},
						want.cx, want.cy, want.sc, want.fnd,
						got.cx, got.cy, got.sc, got.fnd);
			end
		end
	endtask

	// bin driver: predict on acceptance, hold while stalled, idle at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_valid <= 1'b0;
		end else begin
			if (bin_valid && !bin_stall)
				track_bin('{score_value, axis, row_last});
			if (bin_valid && bin_stall) begin
				// payload stays put until taken
			end else if (pending_bins.size() != 0 &&
					$urandom_range(0, 99) >= send_idle_pct) begin
				bin_valid   <= 1'b1;
				score_value <= pending_bins[0].value;
				axis        <= pending_bins[0].axis;
				row_last    <= pending_bins[0].last;
				void'(pending_bins.pop_front());
			end else begin
				bin_valid <= 1'b0;
			end
		end
	end

	// result monitor, also drives the stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall)
				check_keypoint('{coord_x, coord_y, score, found});
			res_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_used) begin
			hold_left <= HOLD_CYCLES;
			hold_used <= 1'b1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic push_bin(input score_t v, input logic ax, input logic lst);
		bin_item_t b;
		b = '{v, ax, lst};
		pending_bins.insert(pending_bins.size(), b);
		items_made++;
	endtask

	// mix of full range, tie-prone tiny values, positives and negatives
	function automatic score_t rand_score();
		case ($urandom_range(0, 3))
			0:       return score_t'($urandom);
			1:       return score_t'(int'($urandom_range(0, 4)) - 2);
			2:       return score_t'($urandom_range(1, 32767));
			default: return score_t'(-int'($urandom_range(1, 32768)));
		endcase
	endfunction

	function automatic factor_t pick_factor();
		case ($urandom_range(0, 5))
			0:       return factor_t'(0);
			1:       return factor_t'(16'hFFFF);
			2:       return FACTOR_RESET;
			3:       return factor_t'(1);
			default: return factor_t'($urandom);
		endcase
	endfunction

	task automatic gen_row(input logic ax, input int len);
		for (int i = 0; i < len; i++)
			push_bin(rand_score(), ax, i == len - 1);
	endtask

	function automatic int row_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(9, 40);
		return $urandom_range(1, 8);
	endfunction

	// x row past the counter's top; small values, winner likely in the tail
	task automatic gen_long_row();
		for (int i = 0; i < LONG_ROW_ITEMS; i++) begin
			if (i >= MAX_BINS - 2)
				push_bin(rand_score(), AXIS_X, i == LONG_ROW_ITEMS - 1);
			else
				push_bin(score_t'(int'($urandom_range(0, 200)) - 100), AXIS_X, 1'b0);
		end
		gen_row(AXIS_Y, row_len());
	endtask

	// mostly whole keypoints; the rest stray bins and broken rows
	task automatic gen_random_chunk(input int n);
		int stop;
		stop = items_made + n;
		while (items_made < stop) begin
			case ($urandom_range(0, 9))
				0: begin
					repeat ($urandom_range(1, 6))
						push_bin(score_t'($urandom), logic'($urandom_range(0, 1)),
							$urandom_range(0, 2) == 0);
				end
				1: gen_row(AXIS_Y, row_len());                 // no x row
				2: begin                                       // repeated x rows
					gen_row(AXIS_X, row_len());
					gen_row(AXIS_X, row_len());
					gen_row(AXIS_Y, row_len());
				end
				default: begin
					gen_row(AXIS_X, row_len());
					gen_row(AXIS_Y, row_len());
				end
			endcase
		end
	endtask

	task automatic write_reg(input cfg_idx_t idx, input factor_t data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_X_FACTOR)
			shadow_xf = data;
		else
			shadow_yf = data;
	endtask

	// everything handed over and answered, then let the pipe empty
	task automatic wait_idle();
		while (pending_bins.size() != 0 || bin_valid || expected_kp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		factor_t xf;
		factor_t yf;
		int      chunk;
		int      goal;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 35;
		recv_idle_pct = 81;
		@(negedge clk);

		// directed, factors left at reset
		// y row end with no x row: x state still zero, so not found
		push_bin(16'sh7FFF, AXIS_Y, 1'b1);
		// row start loads even the most negative value; tie keeps the first bin
		push_bin(16'sh8000, AXIS_X, 1'b0);
		push_bin(16'sd5,    AXIS_X, 1'b0);
		push_bin(16'sd5,    AXIS_X, 1'b0);
		push_bin(16'sd3,    AXIS_X, 1'b1);
		push_bin(16'sh7FFF, AXIS_Y, 1'b0);
		push_bin(-16'sd1,   AXIS_Y, 1'b1);
		// repeated x rows: the last one counts
		push_bin(16'sd100,  AXIS_X, 1'b1);
		push_bin(16'sd16,   AXIS_X, 1'b0);
		push_bin(16'sd200,  AXIS_X, 1'b1);
		push_bin(-16'sd5,   AXIS_Y, 1'b0);
		push_bin(16'sd300,  AXIS_Y, 1'b1);
		// axis switch without row end: counter carries on, no forced load
		push_bin(16'sd50,   AXIS_X, 1'b0);
		push_bin(16'sd60,   AXIS_X, 1'b0);
		push_bin(16'sd70,   AXIS_Y, 1'b0);
		push_bin(16'sd10,   AXIS_Y, 1'b1);
		// negative maxima, then the smallest positive score
		push_bin(-16'sd1,   AXIS_X, 1'b1);
		push_bin(16'sh8000, AXIS_Y, 1'b1);
		push_bin(16'sd1,    AXIS_X, 1'b1);
		push_bin(16'sd1,    AXIS_Y, 1'b1);
		wait_idle();

		items_made = 0;
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin send_idle_pct = 35; recv_idle_pct = 81; end
				1: begin send_idle_pct = 81; recv_idle_pct = 35; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			// the long row of the last phase takes a large share of the items
			goal = (phase == 2) ? ITEM_TARGET
			                    : (ITEM_TARGET - LONG_ROW_ITEMS) * (phase + 1) / 3;
			chunk = 0;
			while (items_made < goal) begin
				// extremes on each phase's first chunk, random after
				if (chunk == 0) begin
					xf = (phase == 1) ? factor_t'(0) : factor_t'(16'hFFFF);
					yf = (phase == 0) ? factor_t'(0) : factor_t'(16'hFFFF);
				end else begin
					xf = pick_factor();
					yf = pick_factor();
				end
				write_reg(REG_X_FACTOR, xf);
				write_reg(REG_Y_FACTOR, yf);
				@(negedge clk);
				if (phase == 2 && chunk == 0) begin
					// block fills and stalls its input under the hold-off
					hold_req = 1'b1;
					gen_random_chunk(CHUNK_ITEMS);
					gen_long_row();
				end else begin
					gen_random_chunk(CHUNK_ITEMS);
				end
				wait_idle();
				chunk++;
			end
		end

		errors += expected_kp.size();
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
